// ----- hw/rtl/dfu_download_state_machine_assert.svh -----
// Assertion macros for the DFU download state machine.
`ifndef DFU_DOWNLOAD_STATE_MACHINE_ASSERT_SVH
`define DFU_DOWNLOAD_STATE_MACHINE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DFU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfu assertion failed");

// Next-cycle implication, disabled in reset.
`define DFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfu assertion failed");

`endif

// ----- hw/rtl/dfu_pkg.sv -----
`default_nettype none

package dfu_pkg;

   typedef struct packed {
      logic [3:0]  operation;
      logic [15:0] block_size;
      logic [3:0]  new_status;
      logic        start_ok;
      logic        write_ok;
      logic        finish_ok;
      logic        abort_ok;
   } req_item_type;

   typedef struct packed {
      logic        accepted;
      logic [3:0]  dfu_state;
      logic [3:0]  dfu_status;
      logic [23:0] poll_timeout;
      logic        start_called;
      logic        write_called;
      logic [15:0] write_size;
      logic        finish_called;
      logic [1:0]  abort_call;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] max_block_size;
      logic [23:0] init_timeout;
      logic [23:0] download_timeout;
      logic [23:0] manifest_timeout;
   } cfg_type;

   localparam logic [3:0] OP_RESET      = 4'd0;
   localparam logic [3:0] OP_DNLOAD     = 4'd1;
   localparam logic [3:0] OP_DNLOAD_END = 4'd2;
   localparam logic [3:0] OP_GETSTATUS  = 4'd3;
   localparam logic [3:0] OP_ACTION     = 4'd4;
   localparam logic [3:0] OP_GETSTATE   = 4'd5;
   localparam logic [3:0] OP_CLRSTATUS  = 4'd6;
   localparam logic [3:0] OP_ABORT      = 4'd7;
   localparam logic [3:0] OP_SETSTATUS  = 4'd8;

   localparam logic [3:0] BSTATE_IDLE     = 4'd2;
   localparam logic [3:0] BSTATE_DN_SYNC  = 4'd3;
   localparam logic [3:0] BSTATE_DN_BUSY  = 4'd4;
   localparam logic [3:0] BSTATE_DN_IDLE  = 4'd5;
   localparam logic [3:0] BSTATE_MAN_SYNC = 4'd6;
   localparam logic [3:0] BSTATE_MAN      = 4'd7;
   localparam logic [3:0] BSTATE_ERROR    = 4'd10;

   localparam logic [3:0] STATUS_OK      = 4'd0;
   localparam logic [3:0] STATUS_STALLED = 4'd15;

   localparam logic [1:0] ABORT_NONE    = 2'd0;
   localparam logic [1:0] ABORT_REQUEST = 2'd1;
   localparam logic [1:0] ABORT_ERROR   = 2'd2;

   localparam logic [1:0] REG_MAX_BLOCK   = 2'd0;
   localparam logic [1:0] REG_INIT_TMO    = 2'd1;
   localparam logic [1:0] REG_DNLOAD_TMO  = 2'd2;
   localparam logic [1:0] REG_MANIFST_TMO = 2'd3;

   localparam logic [15:0] MAX_BLOCK_RESET = 16'd1024;
   localparam logic [23:0] TIMEOUT_RESET   = 24'd200;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DN_SYNC  = 7'b0000010,
      ST_DN_BUSY  = 7'b0000100,
      ST_DN_IDLE  = 7'b0001000,
      ST_MAN_SYNC = 7'b0010000,
      ST_MAN      = 7'b0100000,
      ST_ERROR    = 7'b1000000
   } fsm_state_type;

   function automatic logic [3:0] b_state(fsm_state_type s);
      logic [3:0] code;
      case (s)
         ST_IDLE:     code = BSTATE_IDLE;
         ST_DN_SYNC:  code = BSTATE_DN_SYNC;
         ST_DN_BUSY:  code = BSTATE_DN_BUSY;
         ST_DN_IDLE:  code = BSTATE_DN_IDLE;
         ST_MAN_SYNC: code = BSTATE_MAN_SYNC;
         ST_MAN:      code = BSTATE_MAN;
         default:     code = BSTATE_ERROR;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dfu_if.sv -----
`default_nettype none

interface dfu_req_if
   import dfu_pkg::*;
();
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface dfu_rsp_if
   import dfu_pkg::*;
();
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dfu_csr.sv -----
`default_nettype none

module dfu_csr
   import dfu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MAX_BLOCK:   cfg_in.max_block_size   = pwdata[15:0];
            REG_INIT_TMO:    cfg_in.init_timeout     = pwdata[23:0];
            REG_DNLOAD_TMO:  cfg_in.download_timeout = pwdata[23:0];
            REG_MANIFST_TMO: cfg_in.manifest_timeout = pwdata[23:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_block_size   <= MAX_BLOCK_RESET;
         cfg_ff.init_timeout     <= TIMEOUT_RESET;
         cfg_ff.download_timeout <= TIMEOUT_RESET;
         cfg_ff.manifest_timeout <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_BLOCK:   prdata = {16'd0, cfg_ff.max_block_size};
         REG_INIT_TMO:    prdata = {8'd0, cfg_ff.init_timeout};
         REG_DNLOAD_TMO:  prdata = {8'd0, cfg_ff.download_timeout};
         REG_MANIFST_TMO: prdata = {8'd0, cfg_ff.manifest_timeout};
         default:         prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/dfu_fsm.sv -----
`default_nettype none

module dfu_fsm
   import dfu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire req_item_type  item,
   input  wire cfg_type       cfg,
   output rsp_item_type       result
);

`include "dfu_download_state_machine_assert.svh"

   fsm_state_type state_ff, state_in;
   logic [3:0]    status_ff, status_in;
   logic [15:0]   pend_ff, pend_in;
   logic          begun_ff, begun_in;

   logic          put_en;
   logic [3:0]    put_val;
   logic [24:0]   poll_sum;

   assign poll_sum = {1'b0, cfg.download_timeout} + {1'b0, cfg.init_timeout};

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      pend_in   = pend_ff;
      begun_in  = begun_ff;
      put_en    = 1'b0;
      put_val   = STATUS_OK;

      result.accepted      = 1'b1;
      result.poll_timeout  = 24'd0;
      result.start_called  = 1'b0;
      result.write_called  = 1'b0;
      result.write_size    = 16'd0;
      result.finish_called = 1'b0;
      result.abort_call    = ABORT_NONE;

      case (item.operation)
         OP_RESET: begin
            state_in  = ST_IDLE;
            status_in = STATUS_OK;
            pend_in   = 16'd0;
            begun_in  = 1'b0;
         end
         OP_DNLOAD: begin
            if (item.block_size > cfg.max_block_size) begin
               put_en          = 1'b1;
               put_val         = STATUS_STALLED;
               result.accepted = 1'b0;
            end else if (state_ff == ST_IDLE) begin
               if (item.block_size != 16'd0) begin
                  pend_in  = item.block_size;
                  begun_in = 1'b0;
               end else begin
                  put_en          = 1'b1;
                  put_val         = STATUS_STALLED;
                  result.accepted = 1'b0;
               end
            end else if (state_ff == ST_DN_IDLE) begin
               if (item.block_size != 16'd0) begin
                  pend_in = item.block_size;
               end else begin
                  state_in = ST_MAN_SYNC;
               end
            end else begin
               result.accepted = 1'b0;
            end
         end
         OP_DNLOAD_END: begin
            state_in = ST_DN_SYNC;
         end
         OP_GETSTATUS: begin
            if (state_ff == ST_DN_SYNC) begin
               state_in = ST_DN_BUSY;
               if (begun_ff) begin
                  result.poll_timeout = cfg.download_timeout;
               end else if (poll_sum[24]) begin
                  result.poll_timeout = '1;
               end else begin
                  result.poll_timeout = poll_sum[23:0];
               end
            end else if (state_ff == ST_MAN_SYNC) begin
               state_in            = ST_MAN;
               result.poll_timeout = cfg.manifest_timeout;
            end
         end
         OP_ACTION: begin
            if (state_ff == ST_DN_BUSY) begin
               if (!begun_ff) begin
                  result.start_called = 1'b1;
                  begun_in            = item.start_ok;
               end
               if (begun_ff || item.start_ok) begin
                  result.write_called = 1'b1;
                  result.write_size   = pend_ff;
                  if (item.write_ok) begin
                     state_in = ST_DN_IDLE;
                  end
               end
            end else if (state_ff == ST_MAN) begin
               result.finish_called = 1'b1;
               if (item.finish_ok) begin
                  state_in = ST_IDLE;
               end
            end
         end
         OP_GETSTATE: begin
         end
         OP_CLRSTATUS: begin
            put_en  = 1'b1;
            put_val = STATUS_OK;
         end
         OP_ABORT: begin
            if (state_ff == ST_IDLE || state_ff == ST_DN_SYNC || state_ff == ST_DN_IDLE ||
                state_ff == ST_MAN_SYNC) begin
               result.abort_call = ABORT_REQUEST;
               if (item.abort_ok) begin
                  state_in = ST_IDLE;
               end
            end
         end
         OP_SETSTATUS: begin
            put_en  = 1'b1;
            put_val = item.new_status;
         end
         default: begin
            result.accepted = 1'b0;
         end
      endcase

      if (put_en) begin
         if (put_val == STATUS_OK) begin
            if (state_ff == ST_ERROR) begin
               state_in = ST_IDLE;
            end
         end else if (state_ff != ST_ERROR) begin
            state_in          = ST_ERROR;
            result.abort_call = ABORT_ERROR;
         end
         status_in = put_val;
      end

      result.dfu_state  = b_state(state_in);
      result.dfu_status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_OK;
         pend_ff   <= 16'd0;
         begun_ff  <= 1'b0;
      end else if (fire) begin
         state_ff  <= state_in;
         status_ff <= status_in;
         pend_ff   <= pend_in;
         begun_ff  <= begun_in;
      end
   end

   `DFU_ASSERT_NEXT(a_hold_when_idle, clock, reset, !fire,
      $stable(state_ff) && $stable(status_ff) && $stable(begun_ff))
   `DFU_ASSERT_IMPLY(a_write_from_busy, clock, reset, fire && result.write_called,
      state_ff == ST_DN_BUSY)
   `DFU_ASSERT_IMPLY(a_finish_from_man, clock, reset, fire && result.finish_called,
      state_ff == ST_MAN)
   `DFU_ASSERT_NEXT(a_reset_op, clock, reset, fire && item.operation == OP_RESET,
      state_ff == ST_IDLE && status_ff == STATUS_OK && !begun_ff)
   `DFU_ASSERT_IMPLY(a_error_note, clock, reset,
      fire && result.abort_call == ABORT_ERROR,
      state_ff != ST_ERROR && state_in == ST_ERROR)

endmodule

`default_nettype wire

// ----- hw/rtl/dfu_download_state_machine.sv -----
// Channel    | Dir | Handshake          | Payload
// req_chan   | in  | valid/ready        | one DFU request
// rsp_chan   | out | valid/ready        | one result per request
// csr (APB)  | in  | psel/penable/pready| 4 config registers, 32-bit data
//
// The request lands in the input stage; its result is registered in the output stage when that stage is free.
// Sustains one request per cycle while rsp_chan.ready is high; the state update sits between the two registers.
// Synchronous active-high reset clears both stages, the DFU state and the config registers.
// A stalled result holds in its register while one more request waits in the input stage.
`default_nettype none

module dfu_download_state_machine
   import dfu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   dfu_req_if.sink          req_chan,
   dfu_rsp_if.source        rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   cfg_type      cfg;
   req_item_type in_item_ff;
   logic         in_valid_ff;
   rsp_item_type out_item_ff;
   logic         out_valid_ff;
   rsp_item_type step_result;
   logic         advance;

   dfu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff <= req_chan.item;
      end
   end

   dfu_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.item  = out_item_ff;

endmodule

`default_nettype wire
